FILE: rtl/core/sff_pkg.sv
// sff_pkg: shared types, widths, constants and helper functions of the
// stationary frame filter. No dependencies.
package sff_pkg;

  // sample, register and config port widths
  localparam int SAMPLE_W    = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_GAIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_GAIN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CROSS_GAIN = 2'd2;

  // shared multiplier operand, product and wide sum widths
  localparam int OPND_W = 33;
  localparam int PROD_W = 2 * OPND_W;
  localparam int SUM_W  = PROD_W + 1;
  // width of the state update accumulators
  localparam int NEW_W  = 52;
  // cordic datapath width, q2.30 with guard bits
  localparam int CRD_W  = 34;

  localparam logic signed [SUM_W-1:0] RND_30 = SUM_W'(64'sd536870912);
  localparam logic signed [SUM_W-1:0] RND_16 = SUM_W'(64'sd32768);

  // cordic start gain, q2.30
  localparam logic signed [CRD_W-1:0] CORDIC_START_GAIN = CRD_W'(64'sd652032874);
  localparam int ATAN_ENTRIES = 24;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_ROT,
    ST_FIX,
    ST_MAC,
    ST_DONE
  } state_t;

  // arctangent of 2^-i in binary angle units, 2^32 per turn
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051E;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2F;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2FA;
      5'd15:   val = 32'h0000517D;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A30;
      5'd19:   val = 32'h00000518;
      5'd20:   val = 32'h0000028C;
      5'd21:   val = 32'h00000146;
      5'd22:   val = 32'h000000A3;
      5'd23:   val = 32'h00000051;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

  // saturate a wide sum to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] res;
    if (v[SUM_W-1:31] == '0 || v[SUM_W-1:31] == '1) begin
      res = v[31:0];
    end else if (v[SUM_W-1]) begin
      res = 32'sh80000000;
    end else begin
      res = 32'sh7FFFFFFF;
    end
    return res;
  endfunction

  // saturate a 33-bit value to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
    logic signed [15:0] res;
    if (v[32:15] == '0 || v[32:15] == '1) begin
      res = v[15:0];
    end else if (v[32]) begin
      res = 16'sh8000;
    end else begin
      res = 16'sh7FFF;
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/sff_if.sv
// sff_if: valid/ready channel interfaces for sample words and result words.
// Depends on sff_pkg for the field widths.
interface sff_sample_if;
  import sff_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] alpha_sample;
  logic signed [SAMPLE_W-1:0] beta_sample;
  logic signed [SAMPLE_W-1:0] frequency;

  modport source (output valid, alpha_sample, beta_sample, frequency, input ready);
  modport sink   (input valid, alpha_sample, beta_sample, frequency, output ready);
endinterface

interface sff_result_if;
  import sff_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] alpha_filtered;
  logic signed [SAMPLE_W-1:0] beta_filtered;

  modport source (output valid, alpha_filtered, beta_filtered, input ready);
  modport sink   (input valid, alpha_filtered, beta_filtered, output ready);
endinterface

FILE: rtl/core/sff_mult.sv
// sff_mult: shared signed multiplier with a registered product.
// Depends on sff_pkg for operand and product widths.
module sff_mult (
  input  logic                                 clk,
  input  logic signed [sff_pkg::OPND_W-1:0]    a,
  input  logic signed [sff_pkg::OPND_W-1:0]    b,
  output logic signed [sff_pkg::PROD_W-1:0]    prod
);
  import sff_pkg::*;

  // product register, one multiply per cycle
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

FILE: rtl/core/stationary_frame_filter.sv
// stationary_frame_filter: top level of the alpha-beta low-pass filter.
// Depends on sff_pkg, sff_if (channel interfaces) and sff_mult.
//
// Usage:
//   samples carries one word of alpha_sample, beta_sample (q1.15) and
//   frequency; results carries alpha_filtered and beta_filtered (q1.15).
//   Both are valid/ready channels; a word moves when valid and ready are high.
//   Registers angle_gain, error_gain and cross_gain must be written through
//   cfg_we/cfg_index/cfg_data only while the block is idle; the block itself
//   does not enforce this. An unknown index is ignored.
//   One word is worked on at a time. A shared multiplier forms the two gain
//   products, a shift-add cordic unit takes one step per cycle, then the
//   multiplier runs eight products for rotation and state update.
//   The result sits in an output register, so a stalled receiver holds one
//   word while the next sample is already being worked on; the block waits
//   only if a second result is ready before the first is taken.
//   Reset (rst, synchronous) clears the filter state, the gain registers,
//   the sequencer and the output valid flag; output data is not cleared.
module stationary_frame_filter #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sff_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sff_pkg::CFG_DATA_W-1:0]      cfg_data,
  sff_sample_if.sink                          samples,
  sff_result_if.source                        results
);
  import sff_pkg::*;

  localparam int ITER_W = $clog2(CORDIC_ITERATIONS);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);
  localparam logic [3:0] GAIN_LAST = 4'd2;
  localparam logic [3:0] MAC_LAST  = 4'd8;

  // configuration registers
  logic signed [31:0] angle_gain;
  logic        [15:0] error_gain;
  logic signed [31:0] cross_gain;

  // filter state
  logic signed [31:0] alpha_state;
  logic signed [31:0] beta_state;

  // captured sample word
  logic signed [SAMPLE_W-1:0] a_in;
  logic signed [SAMPLE_W-1:0] b_in;
  logic signed [SAMPLE_W-1:0] freq;

  // sequencer
  state_t            state;
  state_t            state_next;
  logic [3:0]        cnt;
  logic [ITER_W-1:0] iter;
  logic              load_out;

  // cordic unit
  logic                    flip;
  logic signed [CRD_W-1:0] cx;
  logic signed [CRD_W-1:0] cy;
  logic signed [CRD_W-1:0] cz;
  logic signed [CRD_W-1:0] dx;
  logic signed [CRD_W-1:0] dy;
  logic signed [CRD_W-1:0] atan_val;

  // multiply-accumulate datapath
  logic signed [OPND_W-1:0] opnd_a;
  logic signed [OPND_W-1:0] opnd_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] acc;
  logic signed [31:0]       factor;
  logic signed [31:0]       a_rot;
  logic signed [31:0]       b_rot;
  logic signed [OPND_W-1:0] a_err;
  logic signed [OPND_W-1:0] b_err;
  logic signed [NEW_W-1:0]  a_new;
  logic signed [NEW_W-1:0]  b_new;
  logic signed [SUM_W-1:0]  rot_sum;
  logic signed [SUM_W-1:0]  term;
  logic signed [31:0]       fin_alpha;
  logic signed [31:0]       fin_beta;

  // output register
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_alpha;
  logic signed [SAMPLE_W-1:0] out_beta;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_gain <= '0;
      error_gain <= '0;
      cross_gain <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANGLE_GAIN: angle_gain <= $signed(cfg_data[31:0]);
        REG_ERROR_GAIN: error_gain <= cfg_data[15:0];
        REG_CROSS_GAIN: cross_gain <= $signed(cfg_data[31:0]);
        default: ;
      endcase
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) state_next = ST_GAIN;
      end
      ST_GAIN: begin
        if (cnt == GAIN_LAST) state_next = ST_ROT;
      end
      ST_ROT: begin
        if (iter == ITER_LAST) state_next = ST_FIX;
      end
      ST_FIX: begin
        state_next = ST_MAC;
      end
      ST_MAC: begin
        if (cnt == MAC_LAST) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || results.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      iter <= '0;
    end else begin
      if (state_next != state) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 4'd1;
      end
      if (state == ST_ROT) begin
        iter <= iter + ITER_W'(1);
      end else begin
        iter <= '0;
      end
    end
  end

  // error terms against the rotated state
  assign a_err = OPND_W'($signed({a_in, 1'b0})) - OPND_W'(a_rot);
  assign b_err = OPND_W'($signed({b_in, 1'b0})) - OPND_W'(b_rot);

  // operand select for the shared multiplier
  always_comb begin
    opnd_a = '0;
    opnd_b = '0;
    if (state == ST_GAIN) begin
      opnd_a = (cnt == 4'd0) ? OPND_W'(angle_gain) : OPND_W'(cross_gain);
      opnd_b = OPND_W'(freq);
    end else if (state == ST_MAC) begin
      case (cnt)
        4'd0: begin opnd_a = OPND_W'(alpha_state); opnd_b = OPND_W'($signed(cx[31:0])); end
        4'd1: begin opnd_a = OPND_W'(beta_state);  opnd_b = OPND_W'($signed(cy[31:0])); end
        4'd2: begin opnd_a = OPND_W'(alpha_state); opnd_b = OPND_W'($signed(cy[31:0])); end
        4'd3: begin opnd_a = OPND_W'(beta_state);  opnd_b = OPND_W'($signed(cx[31:0])); end
        4'd4: begin opnd_a = a_err;                opnd_b = OPND_W'(error_gain); end
        4'd5: begin opnd_a = OPND_W'(a_rot);       opnd_b = OPND_W'(factor); end
        4'd6: begin opnd_a = b_err;                opnd_b = OPND_W'(error_gain); end
        4'd7: begin opnd_a = OPND_W'(b_rot);       opnd_b = OPND_W'(factor); end
        default: begin opnd_a = '0; opnd_b = '0; end
      endcase
    end
  end

  sff_mult u_mult (
    .clk  (clk),
    .a    (opnd_a),
    .b    (opnd_b),
    .prod (prod)
  );

  // rotation sum with rounding, and rounded q16 product term
  always_comb begin
    if (cnt == 4'd2) begin
      rot_sum = SUM_W'(acc) - SUM_W'(prod) + RND_30;
    end else begin
      rot_sum = SUM_W'(acc) + SUM_W'(prod) + RND_30;
    end
    term = (SUM_W'(prod) + RND_16) >>> 16;
  end

  // cordic step operands
  assign dx       = cy >>> iter;
  assign dy       = cx >>> iter;
  assign atan_val = $signed(CRD_W'(atan_entry(5'(iter))));

  // saturated new state
  assign fin_alpha = sat32(SUM_W'(a_new));
  assign fin_beta  = sat32(SUM_W'(b_new));

  // datapath registers
  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      a_in <= samples.alpha_sample;
      b_in <= samples.beta_sample;
      freq <= samples.frequency;
    end
    case (state)
      ST_GAIN: begin
        // angle word folded into the right half plane
        if (cnt == 4'd1) begin
          flip <= prod[31] ^ prod[30];
          cz   <= CRD_W'($signed({prod[31] ^ (prod[31] ^ prod[30]), prod[30:16], 16'h0000}));
          cx   <= CORDIC_START_GAIN;
          cy   <= '0;
        end else if (cnt == GAIN_LAST) begin
          factor <= sat32(SUM_W'(prod));
        end
      end
      ST_ROT: begin
        // one shift-add rotation step
        if (!cz[CRD_W-1]) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - atan_val;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + atan_val;
        end
      end
      ST_FIX: begin
        if (flip) begin
          cx <= -cx;
          cy <= -cy;
        end
      end
      ST_MAC: begin
        // consume the product issued in the previous cycle
        case (cnt)
          4'd1: acc   <= prod;
          4'd2: a_rot <= sat32(rot_sum >>> 30);
          4'd3: acc   <= prod;
          4'd4: b_rot <= sat32(rot_sum >>> 30);
          4'd5: a_new <= NEW_W'(alpha_state) + NEW_W'(term);
          4'd6: b_new <= NEW_W'(beta_state) + NEW_W'(term);
          4'd7: b_new <= b_new + NEW_W'(term);
          4'd8: a_new <= a_new - NEW_W'(term);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // filter state update
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_state <= '0;
      beta_state  <= '0;
    end else if (load_out) begin
      alpha_state <= fin_alpha;
      beta_state  <= fin_beta;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      out_alpha <= sat16((33'(fin_alpha) + 33'sd1) >>> 1);
      out_beta  <= sat16((33'(fin_beta) + 33'sd1) >>> 1);
    end
  end

  assign results.valid          = out_valid;
  assign results.alpha_filtered = out_alpha;
  assign results.beta_filtered  = out_beta;

endmodule

FILE: rtl/core/sff_checker.sv
// sff_checker: port-level assertions for the stationary frame filter,
// bound to the top level. Depends on sff_pkg and stationary_frame_filter.
module sff_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [sff_pkg::SAMPLE_W-1:0]  out_alpha,
  input logic signed [sff_pkg::SAMPLE_W-1:0]  out_beta
);
  import sff_pkg::*;

  // one word at a time: no new sample right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("sample taken while previous word in progress");

  // reset empties the output register and opens the input
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("output or input handshake wrong after reset");

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result word dropped under stall");

  // stalled result payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_alpha) && $stable(out_beta)))
    else $error("result word changed under stall");

endmodule

bind stationary_frame_filter sff_checker u_sff_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_alpha (results.alpha_filtered),
  .out_beta  (results.beta_filtered)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for stationary_frame_filter. Each result word is checked
// against a fixed-point prediction of the rotate, error and cross-coupling update.
// Depends on sff_pkg, stationary_frame_filter and the sff_sample_if / sff_result_if channel interfaces.
module tb_top;
  import sff_pkg::*;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int PHASE_WORDS = 230;
  localparam int RANDOM_PHASES = 8;
  localparam int CYCLE_LIMIT = 1200000;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam longint START_GAIN_Q30 = 64'sd652032874;
  localparam longint HALF_LSB_30 = 64'sd536870912;
  localparam longint HALF_LSB_16 = 64'sd32768;
  // arctangent of 2^-i, 2^32 units per turn
  localparam longint ATAN_TURN [0:23] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] alpha_sample;
    logic signed [SAMPLE_W-1:0] beta_sample;
    logic signed [SAMPLE_W-1:0] frequency;
  } sample_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] alpha_filtered;
    logic signed [SAMPLE_W-1:0] beta_filtered;
  } filtered_word_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  sff_sample_if samp();
  sff_result_if res();

  stationary_frame_filter #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samp),
    .results   (res)
  );

  always #6 clk = ~clk;

  // predicted gains and filter state
  longint angle_gain_q = 0;
  longint error_gain_q = 0;
  longint cross_gain_q = 0;
  longint alpha_acc = 0;
  longint beta_acc = 0;

  filtered_word_t filtered_q[$];
  filtered_word_t got_word;
  filtered_word_t want_word;
  int mismatches = 0;
  int cycles = 0;

  // receiver stall pattern state
  int pattern_cnt = 0;
  int stall_mode = 0;
  int stall_left = 0;

  // random walk of the stimulus signal
  longint walk_alpha = 0;
  longint walk_beta = 0;
  longint walk_freq = 0;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // shift-add sine and cosine of a 16-bit binary angle, q2.30
  function automatic void cordic_sincos(input logic [15:0] angle, output longint cos_q,
                                        output longint sin_q);
    logic [31:0] turn;
    logic        flip;
    longint      x, y, z, dx, dy;
    int          i;
    turn = {angle, 16'h0000};
    flip = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
    if (flip) turn = turn + 32'h80000000;
    x = START_GAIN_Q30;
    y = 0;
    z = longint'($signed(turn));
    for (i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURN[i];
      end
    end
    cos_q = flip ? -x : x;
    sin_q = flip ? -y : y;
  endfunction

  // advance the filter state by one sample word and return the output word
  function automatic filtered_word_t filter_update(input sample_word_t w);
    longint a_in, b_in, fr, turn_prod, c, s, a_rot, b_rot, a_err, b_err, factor;
    filtered_word_t r;
    a_in = longint'($signed(w.alpha_sample));
    b_in = longint'($signed(w.beta_sample));
    fr = longint'($signed(w.frequency));
    turn_prod = angle_gain_q * fr;
    cordic_sincos(turn_prod[31:16], c, s);
    a_rot = clamp((alpha_acc * c - beta_acc * s + HALF_LSB_30) >>> 30,
                  -64'sd2147483648, 64'sd2147483647);
    b_rot = clamp((alpha_acc * s + beta_acc * c + HALF_LSB_30) >>> 30,
                  -64'sd2147483648, 64'sd2147483647);
    a_err = a_in * 2 - a_rot;
    b_err = b_in * 2 - b_rot;
    factor = clamp(cross_gain_q * fr, -64'sd2147483648, 64'sd2147483647);
    alpha_acc = clamp(alpha_acc + ((a_err * error_gain_q + HALF_LSB_16) >>> 16)
                      - ((b_rot * factor + HALF_LSB_16) >>> 16),
                      -64'sd2147483648, 64'sd2147483647);
    beta_acc = clamp(beta_acc + ((b_err * error_gain_q + HALF_LSB_16) >>> 16)
                     + ((a_rot * factor + HALF_LSB_16) >>> 16),
                     -64'sd2147483648, 64'sd2147483647);
    r.alpha_filtered = 16'(clamp((alpha_acc + 1) >>> 1, -64'sd32768, 64'sd32767));
    r.beta_filtered = 16'(clamp((beta_acc + 1) >>> 1, -64'sd32768, 64'sd32767));
    return r;
  endfunction

  task automatic flag_error(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
  endtask

  // one register write; the caller lowers cfg_we after the last one
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_ANGLE_GAIN: angle_gain_q = longint'($signed(data));
      REG_ERROR_GAIN: error_gain_q = longint'(data[15:0]);
      REG_CROSS_GAIN: cross_gain_q = longint'($signed(data));
      default: ;
    endcase
  endtask

  // hold the sender until every predicted word has come back
  task automatic drain_results();
    samp.valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic program_gains(input logic [31:0] ag, input logic [31:0] eg,
                               input logic [31:0] cg);
    drain_results();
    write_reg(REG_ANGLE_GAIN, ag);
    write_reg(REG_ERROR_GAIN, eg);
    write_reg(REG_CROSS_GAIN, cg);
    cfg_we <= 1'b0;
  endtask

  // present one sample word and predict its result once accepted; valid stays high
  task automatic send_word(input sample_word_t w);
    samp.valid <= 1'b1;
    samp.alpha_sample <= w.alpha_sample;
    samp.beta_sample <= w.beta_sample;
    samp.frequency <= w.frequency;
    @(posedge clk);
    while (samp.ready !== 1'b1) @(posedge clk);
    filtered_q.push_back(filter_update(w));
  endtask

  function automatic logic [31:0] extreme_or_random(input logic [31:0] lo,
                                                    input logic [31:0] hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      2: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // mostly a slowly moving signal with steady frequency, sometimes raw noise
  function automatic sample_word_t next_word();
    logic [63:0] raw;
    sample_word_t w;
    if ($urandom_range(0, 3) == 0) begin
      raw = {$urandom, $urandom};
      w = raw[47:0];
    end else begin
      walk_alpha = clamp(walk_alpha + longint'($urandom_range(0, 4096)) - 2048,
                         -32768, 32767);
      walk_beta = clamp(walk_beta + longint'($urandom_range(0, 4096)) - 2048,
                        -32768, 32767);
      if ($urandom_range(0, 31) == 0)
        walk_freq = longint'($urandom_range(0, 65535)) - 32768;
      w.alpha_sample = walk_alpha[15:0];
      w.beta_sample = walk_beta[15:0];
      w.frequency = walk_freq[15:0];
    end
    return w;
  endfunction

  // reset gains are zero, so every output stays zero
  task automatic test_reset_defaults();
    send_word({16'sh7FFF, 16'sh8000, 16'sh7FFF});
    send_word({16'sh8000, 16'sh7FFF, 16'sh8000});
    send_word({16'sh0000, 16'sh0000, 16'sh0000});
  endtask

  // full error gain with no rotation: step response up to the rails
  task automatic test_error_gain_step();
    int k;
    program_gains(32'h0, 32'hFFFFFFFF, 32'h0);
    for (k = 0; k < 4; k++) send_word({16'sh7FFF, 16'sh8000, 16'sh0000});
    for (k = 0; k < 2; k++) send_word({16'sh8000, 16'sh7FFF, 16'sh0000});
  endtask

  // extreme angle gain, angle wrap, and a write to an unmapped index
  task automatic test_angle_extremes();
    drain_results();
    write_reg(REG_UNMAPPED, 32'hFFFFFFFF);
    write_reg(REG_ANGLE_GAIN, 32'h7FFFFFFF);
    write_reg(REG_ERROR_GAIN, 32'h00008000);
    write_reg(REG_CROSS_GAIN, 32'h00000000);
    cfg_we <= 1'b0;
    send_word({16'sh4000, 16'shC000, 16'sh7FFF});
    send_word({16'sh4000, 16'shC000, 16'sh8000});
    send_word({16'sh7FFF, 16'sh7FFF, 16'sh0001});
    send_word({16'sh8000, 16'sh8000, 16'shFFFF});
    send_word({16'sh1234, 16'shEDCB, 16'sh0004});
  endtask

  // cross factor saturating in both directions
  task automatic test_cross_saturation();
    program_gains(32'h80000000, 32'h0, 32'h7FFFFFFF);
    send_word({16'sh0000, 16'sh0000, 16'sh7FFF});
    send_word({16'sh0000, 16'sh0000, 16'sh8000});
    send_word({16'sh0100, 16'shFF00, 16'sh0002});
    program_gains(32'h40000000, 32'h00001234, 32'h80000000);
    send_word({16'sh2000, 16'sh6000, 16'sh7FFF});
    send_word({16'shE000, 16'sh9000, 16'sh8001});
    send_word({16'sh7FFF, 16'sh8000, 16'sh7FFF});
  endtask

  // random gain settings, each followed by bursts of sample words
  task automatic test_random_phases();
    logic [31:0] ag, eg, cg;
    int phase, sent, burst, gap, k;
    bit steady;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ((phase == 0) ? 1 : $urandom_range(0, 3))
        0: begin
          ag = $urandom;
          eg = $urandom;
          cg = $urandom;
        end
        1: begin
          ag = $urandom_range(0, 32'h00040000);
          if ($urandom_range(0, 1)) ag = -ag;
          eg = $urandom_range(256, 65535);
          cg = $urandom_range(0, 8192);
          if ($urandom_range(0, 1)) cg = -cg;
        end
        2: begin
          ag = extreme_or_random(32'h80000000, 32'h7FFFFFFF);
          eg = extreme_or_random(32'h0, 32'h0000FFFF);
          cg = extreme_or_random(32'h80000000, 32'h7FFFFFFF);
        end
        default: begin
          ag = $urandom_range(0, 32'h00400000);
          eg = $urandom_range(0, 4096);
          cg = $urandom_range(0, 512);
          if ($urandom_range(0, 1)) cg = -cg;
        end
      endcase
      program_gains(ag, eg, cg);
      steady = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        burst = $urandom_range(1, 16);
        for (k = 0; k < burst && sent < PHASE_WORDS; k++) begin
          send_word(next_word());
          sent++;
        end
        gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        if ($urandom_range(0, 59) == 0) begin
          drain_results();
        end else if (gap != 0) begin
          samp.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // receiver ready: always on, coin toss, or long stalls, mode redrawn when pattern_cnt[8:0] is zero
  always @(posedge clk) begin
    pattern_cnt <= pattern_cnt + 1;
    if (pattern_cnt[8:0] == 9'd0) stall_mode <= $urandom_range(0, 2);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: res.ready <= 1'b1;
        1: res.ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 29) == 0) begin
            stall_left <= $urandom_range(20, 80);
            res.ready <= 1'b0;
          end else begin
            res.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      got_word.alpha_filtered = res.alpha_filtered;
      got_word.beta_filtered = res.beta_filtered;
      if (filtered_q.size() == 0) begin
        flag_error($sformatf("unexpected word alpha=%0d beta=%0d",
                             got_word.alpha_filtered, got_word.beta_filtered));
      end else begin
        want_word = filtered_q.pop_front();
        if (got_word.alpha_filtered !== want_word.alpha_filtered ||
            got_word.beta_filtered !== want_word.beta_filtered)
          flag_error($sformatf("alpha exp %0d got %0d, beta exp %0d got %0d",
                               want_word.alpha_filtered, got_word.alpha_filtered,
                               want_word.beta_filtered, got_word.beta_filtered));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    samp.valid = 1'b0;
    samp.alpha_sample = '0;
    samp.beta_sample = '0;
    samp.frequency = '0;
    res.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_error_gain_step();
    test_angle_extremes();
    test_cross_saturation();
    test_random_phases();
    drain_results();
    repeat (CORDIC_ITERATIONS + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: stationary_frame_filter.f
rtl/core/sff_pkg.sv
rtl/core/sff_if.sv
rtl/core/sff_mult.sv
rtl/core/stationary_frame_filter.sv
rtl/core/sff_checker.sv
tb/tb_top.sv
